// ----- hw/rtl/raf_pkg.sv -----
// Shared widths, constants and state encoding for the running average filter.
package raf_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int AVG_W         = 16;
  localparam int LEN_W         = 6;
  localparam int WINDOW_RESET  = 20;
  localparam int AVG_POS_LIMIT = 32767;
  localparam int AVG_NEG_LIMIT = 32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } raf_state_t;

endpackage

// ----- hw/rtl/raf_if.sv -----
// Handshake channel interfaces for samples, results and the window length register.
interface raf_in_if;
  import raf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface raf_out_if;
  import raf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] average;
  logic [LEN_W-1:0]        filled;
  modport source (output valid, output average, output filled, input ready);
  modport sink (input valid, input average, input filled, output ready);
endinterface

interface raf_cfg_if;
  import raf_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] window_len;
  modport source (output valid, output window_len, input ready);
  modport sink (input valid, input window_len, output ready);
endinterface

// ----- hw/rtl/raf_sample_mem.sv -----
// Sample store: one-port-read, one-port-write memory with per-entry valid bits.
module raf_sample_mem #(
  parameter int DEPTH  = 32,
  parameter int AW     = 5,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [DATA_W-1:0] wr_data
);

  logic signed [DATA_W-1:0] mem_r [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [DEPTH-1:0]         valid_r;
  logic                     rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem_r[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ----- hw/rtl/raf_divider.sv -----
// Serial restoring divider: signed dividend by unsigned nonzero divisor, one bit per cycle.
module raf_divider #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic [NUM_W-1:0]        quo_mag,
  output logic                    quo_neg
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, q_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // The most negative value negates onto itself, which is its correct magnitude.
      q_r   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign busy    = busy_r;
  assign quo_mag = q_r;
  assign quo_neg = neg_r;

endmodule

// ----- hw/rtl/running_average_filter.sv -----
// Top level of the running average filter: sample store, running sum and serial divide.
//
//   channel  | direction | payload                      | transfer when
//   ---------+-----------+------------------------------+-----------------------
//   cfg_ch   | in        | window_len (6b)              | cfg_ch.valid & ready
//   in_ch    | in        | sample (16b signed)          | in_ch.valid & ready
//   out_ch   | out       | average (16b signed), filled | out_ch.valid & ready
//
// Each sample passes through accept (ST_IDLE), store read (ST_READ), the
// one-bit-per-cycle divider and a check that it has finished (ST_DIV), then the load
// into the output register (ST_OUT); a new sample is accepted only back in ST_IDLE.
// Reset (synchronous, active low) clears the control state and the store valid bits,
// so the store reads as zeros at once with no clearing pass; window_len returns to 20.
// A waiting result holds in the output register while the next sample is accepted;
// only a result still unread when the next quotient is ready stalls the block.
module running_average_filter #(
  parameter int MAX_WINDOW = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  raf_cfg_if.sink   cfg_ch,
  raf_in_if.sink    in_ch,
  raf_out_if.source out_ch
);

  import raf_pkg::*;

  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int LEN_CAP = (MAX_WINDOW < 63) ? MAX_WINDOW : 63;

  raf_state_t                 state_r;
  raf_state_t                 state_nxt;
  logic [LEN_W-1:0]           window_len_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic [AW-1:0]              pos_r;
  logic [AW-1:0]              pos_nxt;
  logic [LEN_W-1:0]           fill_r;
  logic [LEN_W-1:0]           fill_nxt;
  logic [LEN_W-1:0]           len_eff;
  logic                       out_valid_r;
  logic signed [AVG_W-1:0]    average_r;
  logic [LEN_W-1:0]           filled_r;
  logic signed [AVG_W-1:0]    avg_sat;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic                       rd_en;
  logic                       wr_en;
  logic                       div_start;
  logic                       div_busy;
  logic [SUM_W-1:0]           quo_mag;
  logic                       quo_neg;
  logic                       out_load;
  logic                       in_ready;

  raf_sample_mem #(
    .DEPTH  (MAX_WINDOW),
    .AW     (AW),
    .DATA_W (SAMPLE_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (pos_r),
    .rd_data (old_sample),
    .wr_en   (wr_en),
    .wr_addr (pos_r),
    .wr_data (sample_r)
  );

  raf_divider #(
    .NUM_W (SUM_W),
    .DEN_W (LEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num     (sum_nxt),
    .den     (fill_nxt),
    .busy    (div_busy),
    .quo_mag (quo_mag),
    .quo_neg (quo_neg)
  );

  // A zero window acts as one, and a window past the store depth acts as the depth.
  always_comb begin
    if (window_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(window_len_r) > MAX_WINDOW) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = window_len_r;
    end
  end

  assign sum_nxt  = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
  assign pos_nxt  = (int'(pos_r) + 1 >= int'(len_eff)) ? '0 : pos_r + 1'b1;
  assign fill_nxt = (fill_r < len_eff) ? fill_r + 1'b1 : len_eff;

  always_comb begin
    if (quo_neg) begin
      if (quo_mag > SUM_W'(AVG_NEG_LIMIT)) begin
        avg_sat = AVG_W'(-AVG_NEG_LIMIT);
      end else begin
        avg_sat = AVG_W'(-quo_mag);
      end
    end else if (quo_mag > SUM_W'(AVG_POS_LIMIT)) begin
      avg_sat = AVG_W'(AVG_POS_LIMIT);
    end else begin
      avg_sat = AVG_W'(quo_mag);
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          rd_en     = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        wr_en     = 1'b1;
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      window_len_r <= LEN_W'(WINDOW_RESET);
      sum_r        <= '0;
      pos_r        <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        window_len_r <= cfg_ch.window_len;
      end
      if (state_r == ST_READ) begin
        sum_r  <= sum_nxt;
        pos_r  <= pos_nxt;
        fill_r <= fill_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      sample_r <= in_ch.sample;
    end
    if (out_load) begin
      average_r <= avg_sat;
      filled_r  <= fill_r;
    end
  end

  assign cfg_ch.ready   = 1'b1;
  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.average = average_r;
  assign out_ch.filled  = filled_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == ST_DIV)
    else $error("divider busy outside the divide state");

  assert property (@(posedge clk) disable iff (!rst_n)
    int'(pos_r) < MAX_WINDOW)
    else $error("write position beyond the store depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (filled_r != '0) && (int'(filled_r) <= LEN_CAP))
    else $error("fill count of a result out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result loaded outside the output state");

endmodule

// ----- dv/running_average_filter_checker.sv -----
// Checker for the running average filter: predicts every result and compares it at the output.
module running_average_filter_checker
  import raf_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  logic clk,
  input  logic rst_n,
  raf_cfg_if   cfg_ch,
  raf_in_if    in_ch,
  raf_out_if   out_ch,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic [LEN_W-1:0]        filled;
  } avg_result_t;

  logic [LEN_W-1:0]           window_len;
  logic signed [SAMPLE_W-1:0] window_store [MAX_WINDOW];
  int                         window_sum;
  int                         write_slot;
  int                         fill_count;
  avg_result_t                expected_averages [$];
  int                         mismatches = 0;
  int                         queued = 0;

  assign errors  = mismatches;
  assign pending = queued;

  function automatic avg_result_t next_average(input logic signed [SAMPLE_W-1:0] sample);
    int          span;
    int          quotient;
    avg_result_t result;
    if (window_len == '0) begin
      span = 1;
    end else if (int'(window_len) > MAX_WINDOW) begin
      span = MAX_WINDOW;
    end else begin
      span = int'(window_len);
    end
    // Entries left outside a shrunken window stay in the sum until they are overwritten.
    window_sum = window_sum - window_store[write_slot] + sample;
    window_store[write_slot] = sample;
    write_slot = (write_slot + 1 >= span) ? 0 : write_slot + 1;
    fill_count = (fill_count < span) ? fill_count + 1 : span;
    quotient = window_sum / fill_count;
    if (quotient > AVG_POS_LIMIT) quotient = AVG_POS_LIMIT;
    if (quotient < -AVG_NEG_LIMIT) quotient = -AVG_NEG_LIMIT;
    result.average = quotient[AVG_W-1:0];
    result.filled  = fill_count[LEN_W-1:0];
    return result;
  endfunction

  always @(posedge clk) begin
    avg_result_t want;
    if (!rst_n) begin
      window_len = LEN_W'(WINDOW_RESET);
      foreach (window_store[i]) window_store[i] = '0;
      window_sum = 0;
      write_slot = 0;
      fill_count = 0;
      expected_averages.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) window_len = cfg_ch.window_len;
      // The result side is handled first, since a result never belongs to a sample
      // taken in the same transfer cycle.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_averages.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, average %0d filled %0d", $time,
                   $signed(out_ch.average), out_ch.filled);
        end else begin
          want = expected_averages.pop_front();
          if (out_ch.average !== want.average) begin
            mismatches++;
            $display("%0t: average mismatch, expected %0d actual %0d", $time,
                     $signed(want.average), $signed(out_ch.average));
          end
          if (out_ch.filled !== want.filled) begin
            mismatches++;
            $display("%0t: filled mismatch, expected %0d actual %0d", $time,
                     want.filled, out_ch.filled);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) expected_averages.push_back(next_average(in_ch.sample));
    end
    queued <= expected_averages.size();
  end

endmodule

// ----- dv/running_average_filter_tb.sv -----
// Testbench top for the running average filter: clock, reset, stimulus, idling and verdict.
module running_average_filter_tb;
  import raf_pkg::*;

  localparam int MAX_WINDOW      = 32;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 30;
  localparam int DRAIN_CYCLES    = 60;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_PHASE  = 3;
  localparam int PHASES          = 10;
  localparam int CYCLE_LIMIT     = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          steady = 1'b0;
  bit          hold_off_req = 1'b0;
  int          errors;
  int          pending;
  int unsigned cycles = 0;

  logic signed [SAMPLE_W-1:0] corner_samples [9] = '{
    16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555, 16'shAAAA, -16'sd3
  };
  logic [LEN_W-1:0] phase_windows [PHASES] = '{32, 0, 63, 2, 33, 20, 1, 17, 9, 31};

  raf_cfg_if cfg_ch ();
  raf_in_if  in_ch ();
  raf_out_if out_ch ();

  running_average_filter #(
    .MAX_WINDOW(MAX_WINDOW)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  running_average_filter_checker #(
    .MAX_WINDOW(MAX_WINDOW)
  ) i_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .errors (errors),
    .pending(pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_cycles(input int unsigned shortest);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return shortest;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Valid stays high between back-to-back samples; it drops only for a gap.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
    int unsigned gap;
    gap = steady ? 0 : idle_cycles(0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= sample;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // The window register is only written once every result has been taken.
  task automatic write_window(input logic [LEN_W-1:0] span);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.window_len <= span;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (steady || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (idle_cycles(1)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned burst_len;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.sample      <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.window_len <= '0;
    phase_windows[PHASES-1] = LEN_W'($urandom_range(0, 63));
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes and negative averages that must truncate toward zero, reset window.
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    // Shrinking a full window leaves stale entries in the sum, which saturates the average.
    write_window(4);
    repeat (4) send_sample(16'sh7FFF);
    write_window(1);
    repeat (2) send_sample(16'sh7FFF);
    write_window(4);
    repeat (4) send_sample(16'sh8000);
    write_window(1);
    repeat (2) send_sample(16'sh8000);

    for (int p = 0; p < PHASES; p++) begin
      write_window(phase_windows[p]);
      steady = (p % 4 == 2);
      burst_len = $urandom_range(110, 150);
      for (int i = 0; i < burst_len; i++) begin
        // The sender keeps offering samples while the result side holds off.
        if (p == HOLD_OFF_PHASE && i == 10) hold_off_req = 1'b1;
        send_sample(random_sample());
      end
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/raf_pkg.sv
hw/rtl/raf_if.sv
hw/rtl/raf_sample_mem.sv
hw/rtl/raf_divider.sv
hw/rtl/running_average_filter.sv
dv/running_average_filter_checker.sv
dv/running_average_filter_tb.sv
